// ----- rtl/pip_pkg.sv -----
// ----------------------------------------------------------------------------
// pip_pkg
// Shared constants and types for the point-in-polygon crossing test.
// ----------------------------------------------------------------------------
package pip_pkg;

   localparam int MAX_VERTICES = 16;
   localparam int VX_AW        = $clog2(MAX_VERTICES);
   localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
   localparam int COORD_W      = 16;
   localparam int DIFF_W       = COORD_W + 1;
   localparam int PROD_W       = 2 * DIFF_W;
   localparam int IDX_W        = 4;
   localparam int VCNT_W       = 5;
   localparam int OUT_CNT_W    = 5;
   localparam int CNT_SAT      = 31;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TEST = 1'b1;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } vertex_type;

   localparam int VTX_W = $bits(vertex_type);

endpackage

// ----- rtl/pip_req_if.sv -----
// ----------------------------------------------------------------------------
// pip_req_if
// Request channel: vertex load or point test, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pip_req_if;

   logic                                 valid;
   logic                                 ready;
   logic                                 operation;
   logic [pip_pkg::IDX_W-1:0]            vertex_index;
   logic signed [pip_pkg::COORD_W-1:0]   coord_x;
   logic signed [pip_pkg::COORD_W-1:0]   coord_y;

   modport source (
      output valid, operation, vertex_index, coord_x, coord_y,
      input  ready
   );

   modport sink (
      input  valid, operation, vertex_index, coord_x, coord_y,
      output ready
   );

endinterface

// ----- rtl/pip_rsp_if.sv -----
// ----------------------------------------------------------------------------
// pip_rsp_if
// Response channel: inside flag and crossing count, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pip_rsp_if;

   logic                              valid;
   logic                              ready;
   logic                              inside_res;
   logic [pip_pkg::OUT_CNT_W-1:0]     crossing_count;

   modport source (
      output valid, inside_res, crossing_count,
      input  ready
   );

   modport sink (
      input  valid, inside_res, crossing_count,
      output ready
   );

endinterface

// ----- rtl/pip_ram.sv -----
// ----------------------------------------------------------------------------
// pip_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pip_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/point_in_polygon_test.sv -----
// ----------------------------------------------------------------------------
// point_in_polygon_test
// Even-odd crossing test of a point against a polygon held in a vertex RAM.
// ----------------------------------------------------------------------------
// A load request writes one vertex. A test request walks the first
// vertex_count vertices (clipped to the table size), reading one vertex per
// cycle from the single-read-port vertex RAM; each edge then passes the
// difference and product stages of the compare pipeline. Once the result is
// placed in the output register the block is idle again, so the next request
// can be taken in the cycle the response is first offered. The response
// sits in an output register, so a finished result waiting on rsp_ch does
// not stall loads or the start of the next test. csr_wr_data sets
// vertex_count and must only be written while the block is idle. Reading a
// vertex that was never loaded gives an undefined result.
// ----------------------------------------------------------------------------
module point_in_polygon_test (
   input  logic                         clock,
   input  logic                         reset,
   pip_req_if.sink                      req_ch,
   pip_rsp_if.source                    rsp_ch,
   input  logic                         csr_wr_en,
   input  logic [pip_pkg::VCNT_W-1:0]   csr_wr_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_DONE
   } state_type;

   state_type                            state_ff;
   logic [pip_pkg::VCNT_W-1:0]           vcount_ff;
   logic [pip_pkg::CNT_W-1:0]            n_eff;

   logic signed [pip_pkg::COORD_W-1:0]   px_ff;
   logic signed [pip_pkg::COORD_W-1:0]   py_ff;
   logic [pip_pkg::VX_AW-1:0]            addr_ff;
   logic [pip_pkg::VX_AW-1:0]            last_ff;
   logic [pip_pkg::CNT_W-1:0]            count_ff;
   logic                                 par_ff;

   logic                                 rsp_valid_ff;
   logic                                 rsp_inside_ff;
   logic [pip_pkg::OUT_CNT_W-1:0]        rsp_count_ff;

   logic                                 req_acc;
   logic                                 load_ok;
   logic                                 ram_wr_en;
   logic                                 ram_rd_en;
   logic [pip_pkg::VTX_W-1:0]            ram_rd_data;
   pip_pkg::vertex_type                  wr_vtx;
   pip_pkg::vertex_type                  rd_vtx;

   // read-data stage
   logic                                 rd_vld_ff;
   logic                                 rd_first_ff;
   logic                                 rd_last_ff;
   logic                                 wrap_ff;
   pip_pkg::vertex_type                  prev_ff;
   pip_pkg::vertex_type                  first_ff;

   // edge select
   logic                                 edge_vld;
   pip_pkg::vertex_type                  edge_a;
   pip_pkg::vertex_type                  edge_b;
   pip_pkg::vertex_type                  lo_vtx;
   pip_pkg::vertex_type                  hi_vtx;
   logic                                 a_lt_b;
   logic                                 in_span;

   // difference stage
   logic                                 e_vld_ff;
   logic                                 e_last_ff;
   logic                                 e_ok_ff;
   logic signed [pip_pkg::DIFF_W-1:0]    e_sx_ff;
   logic signed [pip_pkg::DIFF_W-1:0]    e_ex_ff;
   logic signed [pip_pkg::DIFF_W-1:0]    e_sy_ff;
   logic signed [pip_pkg::DIFF_W-1:0]    e_ey_ff;

   // product stage
   logic                                 m_vld_ff;
   logic                                 m_last_ff;
   logic                                 m_ok_ff;
   logic signed [pip_pkg::PROD_W-1:0]    m_p1_ff;
   logic signed [pip_pkg::PROD_W-1:0]    m_p2_ff;

   logic                                 c_inc;

   // ------------------------------------------------------------------------
   // config register
   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= '0;
      end else if (csr_wr_en) begin
         vcount_ff <= csr_wr_data;
      end
   end

   assign n_eff = (32'(vcount_ff) > pip_pkg::MAX_VERTICES) ?
                  pip_pkg::CNT_W'(pip_pkg::MAX_VERTICES) : pip_pkg::CNT_W'(vcount_ff);

   // ------------------------------------------------------------------------
   // vertex RAM
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign load_ok      = 32'(req_ch.vertex_index) < pip_pkg::MAX_VERTICES;
   assign ram_wr_en    = req_acc && (req_ch.operation == pip_pkg::OP_LOAD) && load_ok;
   assign ram_rd_en    = (state_ff == ST_READ);
   assign wr_vtx.x     = req_ch.coord_x;
   assign wr_vtx.y     = req_ch.coord_y;
   assign rd_vtx       = pip_pkg::vertex_type'(ram_rd_data);

   pip_ram #(
      .WIDTH (pip_pkg::VTX_W),
      .DEPTH (pip_pkg::MAX_VERTICES)
   ) u_vtx_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (pip_pkg::VX_AW'(req_ch.vertex_index)),
      .wr_data (wr_vtx),
      .rd_en   (ram_rd_en),
      .rd_addr (addr_ff),
      .rd_data (ram_rd_data)
   );

   // ------------------------------------------------------------------------
   // sequencer and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         par_ff       <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ch.ready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         if (c_inc) begin
            count_ff <= pip_pkg::CNT_W'(count_ff + 1'b1);
            par_ff   <= ~par_ff;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_acc && (req_ch.operation == pip_pkg::OP_TEST)) begin
                  px_ff    <= req_ch.coord_x;
                  py_ff    <= req_ch.coord_y;
                  count_ff <= '0;
                  par_ff   <= 1'b0;
                  addr_ff  <= '0;
                  last_ff  <= pip_pkg::VX_AW'(n_eff - pip_pkg::CNT_W'(1));
                  state_ff <= (n_eff == '0) ? ST_DONE : ST_READ;
               end
            end
            ST_READ: begin
               addr_ff <= pip_pkg::VX_AW'(addr_ff + 1'b1);
               if (addr_ff == last_ff) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (m_vld_ff && m_last_ff) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_inside_ff <= par_ff;
                  rsp_count_ff  <= (32'(count_ff) > pip_pkg::CNT_SAT) ?
                                   pip_pkg::OUT_CNT_W'(pip_pkg::CNT_SAT) :
                                   pip_pkg::OUT_CNT_W'(count_ff);
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.inside_res     = rsp_inside_ff;
   assign rsp_ch.crossing_count = rsp_count_ff;

   // ------------------------------------------------------------------------
   // edge pipeline
   assign edge_vld = (rd_vld_ff && !rd_first_ff) || wrap_ff;
   assign edge_a   = prev_ff;
   assign edge_b   = wrap_ff ? first_ff : rd_vtx;
   assign a_lt_b   = edge_a.x < edge_b.x;
   assign lo_vtx   = a_lt_b ? edge_a : edge_b;
   assign hi_vtx   = a_lt_b ? edge_b : edge_a;
   // half-open span; also rejects vertical edges
   assign in_span  = (px_ff >= lo_vtx.x) && (px_ff < hi_vtx.x);
   assign c_inc    = m_vld_ff && m_ok_ff && (m_p1_ff > m_p2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
         wrap_ff   <= 1'b0;
         e_vld_ff  <= 1'b0;
         m_vld_ff  <= 1'b0;
      end else begin
         rd_vld_ff <= ram_rd_en;
         wrap_ff   <= rd_vld_ff && rd_last_ff;
         e_vld_ff  <= edge_vld;
         m_vld_ff  <= e_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_first_ff <= (addr_ff == '0);
      rd_last_ff  <= (addr_ff == last_ff);
      if (rd_vld_ff) begin
         prev_ff <= rd_vtx;
         if (rd_first_ff) begin
            first_ff <= rd_vtx;
         end
      end

      e_last_ff <= wrap_ff;
      e_ok_ff   <= in_span;
      e_sx_ff   <= pip_pkg::DIFF_W'(px_ff) - pip_pkg::DIFF_W'(lo_vtx.x);
      e_ex_ff   <= pip_pkg::DIFF_W'(hi_vtx.x) - pip_pkg::DIFF_W'(lo_vtx.x);
      e_sy_ff   <= pip_pkg::DIFF_W'(py_ff) - pip_pkg::DIFF_W'(lo_vtx.y);
      e_ey_ff   <= pip_pkg::DIFF_W'(hi_vtx.y) - pip_pkg::DIFF_W'(lo_vtx.y);

      m_last_ff <= e_last_ff;
      m_ok_ff   <= e_ok_ff;
      m_p1_ff   <= pip_pkg::PROD_W'(e_ey_ff) * pip_pkg::PROD_W'(e_sx_ff);
      m_p2_ff   <= pip_pkg::PROD_W'(e_sy_ff) * pip_pkg::PROD_W'(e_ex_ff);
   end

endmodule

// ----- rtl/pip_checker.sv -----
// ----------------------------------------------------------------------------
// pip_checker
// Port-level checks for point_in_polygon_test, bound to the top level.
// ----------------------------------------------------------------------------
module pip_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic                              req_operation,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic                              rsp_inside_res,
   input  logic [pip_pkg::OUT_CNT_W-1:0]     rsp_crossing_count
);

   // a load request never produces a response
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_operation == pip_pkg::OP_LOAD) && !rsp_valid
      |=> !rsp_valid)
      else $error("response after load request");

   a_parity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pip_pkg::MAX_VERTICES > pip_pkg::CNT_SAT) ||
                    (rsp_inside_res == rsp_crossing_count[0]))
      else $error("inside flag disagrees with crossing count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_crossing_count) <= pip_pkg::MAX_VERTICES)
      else $error("crossing count above vertex table size");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready
      |=> rsp_valid && $stable(rsp_inside_res) && $stable(rsp_crossing_count))
      else $error("stalled response changed");

   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind point_in_polygon_test pip_checker u_pip_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .req_operation      (req_ch.operation),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_inside_res     (rsp_ch.inside_res),
   .rsp_crossing_count (rsp_ch.crossing_count)
);
